@@ rtl/spr_pkg.sv @@
// Shared types and constants for the slotted page record store.
// No dependencies; imported by the controller, the datapath and the top level.
package spr_pkg;

	localparam int CMD_W    = 2;
	localparam int LEN_W    = 13;
	localparam int SLOTIN_W = 10;
	localparam int POS_W    = 12;
	localparam int BYTE_W   = 8;
	localparam int STAT_W   = 3;
	localparam int FREE_W   = 12;
	localparam int USED_W   = 11;

	localparam int SLOT_BYTES = 4;

	localparam int PAGE_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 8;
	localparam int MAX_SLOTS_DEF    = 1024;

	localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_LENGTH = 3'd1;
	localparam logic [STAT_W-1:0] STAT_NO_SPACE   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_SLOT_RANGE = 3'd3;
	localparam logic [STAT_W-1:0] STAT_DELETED    = 3'd4;
	localparam logic [STAT_W-1:0] STAT_POSITION   = 3'd5;

	typedef struct packed {
		logic load;
		logic alloc_start;
		logic scan;
		logic exec;
		logic look;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic len_zero;
		logic has_del;
		logic found;
		logic out_busy;
	} dp_stat_t;

endpackage

@@ rtl/spr_ctrl.sv @@
// Controller state machine for the slotted page record store.
// Depends on spr_pkg; drives the datapath through ctrl_cmd_t.
module spr_ctrl
	import spr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] command,
	input  dp_stat_t         stat,
	output ctrl_cmd_t        cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ALLOC = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_EXEC  = 3'd3;
	localparam logic [2:0] S_LOOK  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (command == CMD_ALLOC) ? S_ALLOC : S_LOOK;
				end
			end
			S_ALLOC: begin
				cmd.alloc_start = 1'b1;
				if (stat.len_zero)
					state_d = S_FIN;
				else if (stat.has_del)
					state_d = S_SCAN;
				else
					state_d = S_EXEC;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.found)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_FIN;
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = S_FIN;
			end
			S_FIN: begin
				// hold the result until the output register is free
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

@@ rtl/spr_datapath.sv @@
// Datapath of the slotted page record store: page and directory memories,
// page bookkeeping registers and the output register. Depends on spr_pkg.
module spr_datapath
	import spr_pkg::*;
#(
	parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int MAX_SLOTS    = MAX_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_cmd_t           cmd,
	output dp_stat_t            stat,
	input  logic [CMD_W-1:0]    command,
	input  logic [LEN_W-1:0]    record_length,
	input  logic [SLOTIN_W-1:0] slot_number,
	input  logic [POS_W-1:0]    byte_position,
	input  logic [BYTE_W-1:0]   write_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STAT_W-1:0]   status,
	output logic [SLOTIN_W-1:0] given_slot,
	output logic [LEN_W-1:0]    stored_length,
	output logic [BYTE_W-1:0]   read_byte,
	output logic [FREE_W-1:0]   free_bytes,
	output logic [USED_W-1:0]   slots_used
);

	localparam int PA_W  = $clog2(PAGE_BYTES);
	localparam int SL_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int OFS_W = $clog2(PAGE_BYTES + 1);
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int AR_W  =
		$clog2(PAGE_BYTES + HEADER_BYTES + SLOT_BYTES * MAX_SLOTS + 8192) + 1;
	localparam int DE_W  = OFS_W + LEN_W;

	logic [DE_W-1:0]   dir_mem [MAX_SLOTS];
	logic [BYTE_W-1:0] page_mem [PAGE_BYTES];

	logic [CMD_W-1:0]    cmd_q;
	logic [LEN_W-1:0]    len_q;
	logic [SLOTIN_W-1:0] slot_q;
	logic [POS_W-1:0]    pos_q;
	logic [BYTE_W-1:0]   wb_q;
	logic [CNT_W-1:0]    count_q;
	logic [OFS_W-1:0]    fs_q;
	logic [CNT_W-1:0]    del_q;
	logic [SL_W-1:0]     scan_q;
	logic [SL_W-1:0]     idx_s1;
	logic                chk_s1;
	logic                found_q;
	logic [SL_W-1:0]     hit_q;
	logic [DE_W-1:0]     dir_rd_q;
	logic [BYTE_W-1:0]   page_rd_q;
	logic [STAT_W-1:0]   res_status_q;
	logic [SL_W-1:0]     res_given_q;
	logic [LEN_W-1:0]    res_stored_q;
	logic                rd_ok_q;
	logic                out_valid_q;

	logic [SL_W-1:0]   dir_raddr;
	logic [LEN_W-1:0]  rd_len;
	logic [OFS_W-1:0]  rd_ofs;
	logic [AR_W-1:0]   dir_end;
	logic [AR_W-1:0]   fs_ext;
	logic [AR_W-1:0]   free;
	logic [AR_W-1:0]   len_ext;
	logic              room_reuse;
	logic              room_app;
	logic              alloc_ok;
	logic [OFS_W-1:0]  new_fs;
	logic              out_range;
	logic [AR_W-1:0]   addr;
	logic              live;
	logic              pos_ok;
	logic              del_ok;
	logic              acc_ok;
	logic              dir_we;
	logic [SL_W-1:0]   dir_wa;
	logic [DE_W-1:0]   dir_wd;
	logic [PA_W-1:0]   pa;
	logic [STAT_W-1:0] look_status;

	assign dir_raddr = cmd.load ? SL_W'(slot_number) : scan_q;
	assign rd_len    = dir_rd_q[LEN_W-1:0];
	assign rd_ofs    = dir_rd_q[DE_W-1:LEN_W];

	assign dir_end = AR_W'(HEADER_BYTES) + AR_W'(count_q) * AR_W'(SLOT_BYTES);
	assign fs_ext  = AR_W'(fs_q);
	assign free    = (fs_ext > dir_end) ? (fs_ext - dir_end) : '0;
	assign len_ext = AR_W'(len_q);

	assign room_reuse = (free >= len_ext);
	assign room_app   = (count_q < CNT_W'(MAX_SLOTS)) &&
	                    (free >= len_ext + AR_W'(SLOT_BYTES));
	assign alloc_ok   = found_q ? room_reuse : room_app;
	assign new_fs     = fs_q - OFS_W'(len_q);

	assign out_range = (AR_W'(slot_q) >= AR_W'(count_q)) ||
	                   (AR_W'(slot_q) >= AR_W'(MAX_SLOTS));
	assign live      = !out_range && (rd_len != '0);
	assign pos_ok    = (AR_W'(pos_q) < AR_W'(rd_len));
	assign addr      = AR_W'(rd_ofs) + AR_W'(pos_q);
	assign pa        = addr[PA_W-1:0];
	assign del_ok    = cmd.look && live && (cmd_q == CMD_DELETE);
	assign acc_ok    = cmd.look && live && (cmd_q != CMD_DELETE) && pos_ok &&
	                   (addr < AR_W'(PAGE_BYTES));

	always_comb begin
		priority if (out_range)
			look_status = STAT_SLOT_RANGE;
		else if (rd_len == '0)
			look_status = STAT_DELETED;
		else if (cmd_q == CMD_DELETE)
			look_status = STAT_OK;
		else if (!pos_ok)
			look_status = STAT_POSITION;
		else
			look_status = STAT_OK;
	end

	always_comb begin
		dir_we = 1'b0;
		dir_wa = SL_W'(slot_q);
		dir_wd = {rd_ofs, {LEN_W{1'b0}}};
		if (cmd.exec && alloc_ok) begin
			dir_we = 1'b1;
			dir_wa = found_q ? hit_q : SL_W'(count_q);
			dir_wd = {new_fs, len_q};
		end else if (del_ok) begin
			dir_we = 1'b1;
		end
	end

	assign stat.len_zero = (len_q == '0);
	assign stat.has_del  = (del_q != '0);
	assign stat.found    = chk_s1 && (rd_len == '0);
	assign stat.out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (dir_we)
			dir_mem[dir_wa] <= dir_wd;
		dir_rd_q <= dir_mem[dir_raddr];
		if (acc_ok && (cmd_q == CMD_WRITE))
			page_mem[pa] <= wb_q;
		if (cmd.look)
			page_rd_q <= page_mem[pa];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			fs_q        <= OFS_W'(PAGE_BYTES);
			del_q       <= '0;
			chk_s1      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.alloc_start) begin
				chk_s1  <= 1'b0;
				found_q <= 1'b0;
			end
			if (cmd.scan) begin
				chk_s1 <= 1'b1;
				if (stat.found)
					found_q <= 1'b1;
			end
			if (cmd.exec && alloc_ok) begin
				fs_q <= new_fs;
				if (found_q)
					del_q <= del_q - CNT_W'(1);
				else
					count_q <= count_q + CNT_W'(1);
			end
			if (del_ok)
				del_q <= del_q + CNT_W'(1);
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= command;
			len_q  <= record_length;
			slot_q <= slot_number;
			pos_q  <= byte_position;
			wb_q   <= write_byte;
		end
		if (cmd.alloc_start) begin
			scan_q       <= '0;
			res_status_q <= STAT_BAD_LENGTH;
			res_given_q  <= '0;
			res_stored_q <= '0;
			rd_ok_q      <= 1'b0;
		end
		if (cmd.scan) begin
			scan_q <= scan_q + SL_W'(1);
			idx_s1 <= scan_q;
			if (stat.found)
				hit_q <= idx_s1;
		end
		if (cmd.exec) begin
			res_status_q <= alloc_ok ? STAT_OK : STAT_NO_SPACE;
			res_given_q  <= alloc_ok ? (found_q ? hit_q : SL_W'(count_q)) : '0;
			res_stored_q <= alloc_ok ? len_q : '0;
		end
		if (cmd.look) begin
			res_status_q <= look_status;
			res_given_q  <= '0;
			res_stored_q <= out_range ? '0 : rd_len;
			rd_ok_q      <= acc_ok && (cmd_q == CMD_READ);
		end
		if (cmd.emit) begin
			status        <= res_status_q;
			given_slot    <= SLOTIN_W'(res_given_q);
			stored_length <= res_stored_q;
			read_byte     <= rd_ok_q ? page_rd_q : '0;
			free_bytes    <= FREE_W'(free);
			slots_used    <= USED_W'(count_q);
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/slotted_page_record_store_unit.sv @@
// Slotted page record store. Write, read and delete pass from acceptance through
// the look state, with one directory read and one page access, to the result;
// an allocate of zero length goes straight to the result. Other allocates pass
// through the exec state, after a scan for the lowest deleted slot if any: the
// directory is scanned one entry a cycle. One word is in work at a time and the
// next is taken once its result is registered. Reset empties the directory and
// frees the page; record bytes and directory entries are undefined until written.
module slotted_page_record_store_unit
	import spr_pkg::*;
#(
	parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int MAX_SLOTS    = MAX_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CMD_W-1:0]    command,
	input  logic [LEN_W-1:0]    record_length,
	input  logic [SLOTIN_W-1:0] slot_number,
	input  logic [POS_W-1:0]    byte_position,
	input  logic [BYTE_W-1:0]   write_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STAT_W-1:0]   status,
	output logic [SLOTIN_W-1:0] given_slot,
	output logic [LEN_W-1:0]    stored_length,
	output logic [BYTE_W-1:0]   read_byte,
	output logic [FREE_W-1:0]   free_bytes,
	output logic [USED_W-1:0]   slots_used
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	spr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.stat     (stat),
		.cmd      (cmd)
	);

	spr_datapath #(
		.PAGE_BYTES   (PAGE_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.MAX_SLOTS    (MAX_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.command       (command),
		.record_length (record_length),
		.slot_number   (slot_number),
		.byte_position (byte_position),
		.write_byte    (write_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.given_slot    (given_slot),
		.stored_length (stored_length),
		.read_byte     (read_byte),
		.free_bytes    (free_bytes),
		.slots_used    (slots_used)
	);

endmodule

@@ verif/tb_slotted_page_record_store_unit.sv @@
// Self-checking testbench for slotted_page_record_store_unit.
// Needs spr_pkg and the unit; a directed table runs first, then random
// commands, each result checked against its table row or an in-bench page predictor.
`timescale 1ns / 1ps

module tb_slotted_page_record_store_unit;
	import spr_pkg::*;

	localparam int PAGE_LEN     = PAGE_BYTES_DEF;
	localparam int HEAD_LEN     = HEADER_BYTES_DEF;
	localparam int SLOT_LIMIT   = MAX_SLOTS_DEF;
	localparam int RANDOM_WORDS = 800;
	localparam int QUIET_FROM   = 700;
	localparam int CYCLE_LIMIT  = 5_000_000;

	typedef struct packed {
		logic [STAT_W-1:0]   status;
		logic [SLOTIN_W-1:0] given_slot;
		logic [LEN_W-1:0]    stored_length;
		logic [BYTE_W-1:0]   read_byte;
		logic [FREE_W-1:0]   free_bytes;
		logic [USED_W-1:0]   slots_used;
	} page_reply_t;

	typedef struct {
		logic [CMD_W-1:0]    cmd;
		logic [LEN_W-1:0]    len;
		logic [SLOTIN_W-1:0] slot;
		logic [POS_W-1:0]    pos;
		logic [BYTE_W-1:0]   data;
		bit                  fixed;
		page_reply_t         reply;
	} page_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] command = '0;
	logic [LEN_W-1:0] record_length = '0;
	logic [SLOTIN_W-1:0] slot_number = '0;
	logic [POS_W-1:0] byte_position = '0;
	logic [BYTE_W-1:0] write_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STAT_W-1:0] status;
	logic [SLOTIN_W-1:0] given_slot;
	logic [LEN_W-1:0] stored_length;
	logic [BYTE_W-1:0] read_byte;
	logic [FREE_W-1:0] free_bytes;
	logic [USED_W-1:0] slots_used;

	// predicted page contents
	logic [7:0] page_mem [PAGE_LEN];
	bit         page_written [PAGE_LEN];
	int         slot_off [SLOT_LIMIT];
	int         slot_len [SLOT_LIMIT];
	int         dir_count = 0;
	int         free_top = PAGE_LEN;

	page_reply_t pending_replies[$];
	page_cmd_t   directed_rows[$];
	int  mismatches = 0;
	int  cycles = 0;
	bit  quiet = 1'b0;
	int  rx_stall = 0;

	slotted_page_record_store_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .record_length(record_length), .slot_number(slot_number),
		.byte_position(byte_position), .write_byte(write_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .given_slot(given_slot), .stored_length(stored_length),
		.read_byte(read_byte), .free_bytes(free_bytes), .slots_used(slots_used)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int page_free();
		int dir_end;
		dir_end = HEAD_LEN + SLOT_BYTES * dir_count;
		return (free_top <= dir_end) ? 0 : free_top - dir_end;
	endfunction

	// apply one command to the predicted page and return its reply
	function automatic page_reply_t page_step(page_cmd_t c);
		page_reply_t r;
		int hole;
		int addr;
		r = '0;
		r.status = STAT_OK;
		if (c.cmd == CMD_ALLOC) begin
			hole = -1;
			for (int i = 0; i < dir_count; i++)
				if (hole < 0 && slot_len[i] == 0) hole = i;
			if (c.len == 0) begin
				r.status = STAT_BAD_LENGTH;
			end else if (hole >= 0) begin
				if (page_free() < int'(c.len)) begin
					r.status = STAT_NO_SPACE;
				end else begin
					free_top -= int'(c.len);
					slot_off[hole] = free_top;
					slot_len[hole] = int'(c.len);
					r.given_slot = SLOTIN_W'(hole);
					r.stored_length = c.len;
				end
			end else if (dir_count >= SLOT_LIMIT ||
					page_free() < int'(c.len) + SLOT_BYTES) begin
				r.status = STAT_NO_SPACE;
			end else begin
				free_top -= int'(c.len);
				slot_off[dir_count] = free_top;
				slot_len[dir_count] = int'(c.len);
				r.given_slot = SLOTIN_W'(dir_count);
				r.stored_length = c.len;
				dir_count++;
			end
		end else if (int'(c.slot) >= dir_count) begin
			r.status = STAT_SLOT_RANGE;
		end else begin
			r.stored_length = LEN_W'(slot_len[c.slot]);
			if (slot_len[c.slot] == 0) begin
				r.status = STAT_DELETED;
			end else if (c.cmd == CMD_DELETE) begin
				slot_len[c.slot] = 0;
			end else if (int'(c.pos) >= slot_len[c.slot]) begin
				r.status = STAT_POSITION;
			end else begin
				addr = slot_off[c.slot] + int'(c.pos);
				if (c.cmd == CMD_WRITE) begin
					page_mem[addr] = c.data;
					page_written[addr] = 1'b1;
				end else begin
					r.read_byte = page_mem[addr];
				end
			end
		end
		r.free_bytes = FREE_W'(page_free());
		r.slots_used = USED_W'(dir_count);
		return r;
	endfunction

	// a read that would land on a byte never written
	function automatic bit reads_blank(page_cmd_t c);
		return c.cmd == CMD_READ && int'(c.slot) < dir_count && slot_len[c.slot] != 0 &&
			int'(c.pos) < slot_len[c.slot] && !page_written[slot_off[c.slot] + int'(c.pos)];
	endfunction

	task automatic send_word(page_cmd_t c);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c.cmd;
		record_length <= c.len;
		slot_number <= c.slot;
		byte_position <= c.pos;
		write_byte <= c.data;
		do @(posedge clk); while (!in_ready);
		if (c.fixed) begin
			void'(page_step(c));
			pending_replies.insert(pending_replies.size(), c.reply);
		end else begin
			pending_replies.insert(pending_replies.size(), page_step(c));
		end
	endtask

	task automatic add_row(input logic [CMD_W-1:0] cmd, input int len, input int slot,
			input int pos, input int data, input bit fixed, input logic [STAT_W-1:0] st,
			input int given, input int stored, input int rd, input int fr, input int used);
		page_cmd_t c;
		c.cmd = cmd;
		c.len = LEN_W'(len);
		c.slot = SLOTIN_W'(slot);
		c.pos = POS_W'(pos);
		c.data = BYTE_W'(data);
		c.fixed = fixed;
		c.reply = '{st, SLOTIN_W'(given), LEN_W'(stored), BYTE_W'(rd), FREE_W'(fr),
			USED_W'(used)};
		directed_rows.insert(directed_rows.size(), c);
	endtask

	function automatic page_cmd_t random_cmd();
		page_cmd_t c;
		int pick;
		int s;
		c.fixed = 1'b0;
		c.reply = '0;
		c.len = '0;
		c.slot = SLOTIN_W'($urandom);
		c.pos = POS_W'($urandom);
		c.data = BYTE_W'($urandom);
		pick = int'($urandom_range(0, 99));
		if (pick < 25) begin
			c.cmd = CMD_ALLOC;
			pick = int'($urandom_range(0, 99));
			if (pick < 85) c.len = LEN_W'($urandom_range(1, 8));
			else if (pick < 95) c.len = LEN_W'($urandom_range(1, 64));
			else c.len = LEN_W'($urandom);
		end else begin
			c.cmd = (pick < 60) ? CMD_WRITE : (pick < 85) ? CMD_READ : CMD_DELETE;
			// mostly aim at a live record
			if (dir_count > 0 && $urandom_range(0, 4) != 0) begin
				for (int t = 0; t < 8; t++) begin
					s = int'($urandom_range(0, dir_count - 1));
					if (t == 0 || slot_len[s] != 0) c.slot = SLOTIN_W'(s);
				end
				if (slot_len[c.slot] != 0) begin
					c.pos = POS_W'($urandom_range(0, slot_len[c.slot] - 1));
					if (c.cmd == CMD_READ && reads_blank(c))
						for (int p = 0; p < slot_len[c.slot]; p++)
							if (page_written[slot_off[c.slot] + p]) c.pos = POS_W'(p);
				end
			end
			if (reads_blank(c)) c.cmd = CMD_WRITE;
		end
		return c;
	endfunction

	// result side: random stalls, none once the run goes quiet
	always @(posedge clk) begin
		page_reply_t got, want;
		if (out_valid && out_ready) begin
			got = '{status, given_slot, stored_length, read_byte, free_bytes, slots_used};
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %p", got);
			end else begin
				want = pending_replies.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("expected %p, got %p", want, got);
				end
			end
		end
		if (quiet) begin
			out_ready <= 1'b1;
		end else if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			rx_stall <= int'($urandom_range(0, 7));
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		// empty page, extremes and every error code
		add_row(CMD_READ,   0,    0,    0,    0, 1, STAT_SLOT_RANGE, 0, 0,    0,    4088, 0);
		add_row(CMD_ALLOC,  0,    0,    0,    0, 1, STAT_BAD_LENGTH, 0, 0,    0,    4088, 0);
		add_row(CMD_ALLOC,  8191, 0,    0,    0, 1, STAT_NO_SPACE,   0, 0,    0,    4088, 0);
		add_row(CMD_ALLOC,  4085, 0,    0,    0, 1, STAT_NO_SPACE,   0, 0,    0,    4088, 0);
		add_row(CMD_ALLOC,  2048, 0,    0,    0, 1, STAT_OK,         0, 2048, 0,    2036, 1);
		add_row(CMD_WRITE,  0,    0,    2047, 255, 1, STAT_OK,       0, 2048, 0,    2036, 1);
		add_row(CMD_WRITE,  0,    0,    0,    0, 1, STAT_OK,         0, 2048, 0,    2036, 1);
		add_row(CMD_WRITE,  0,    0,    2048, 7, 1, STAT_POSITION,   0, 2048, 0,    2036, 1);
		add_row(CMD_READ,   0,    0,    2047, 0, 1, STAT_OK,         0, 2048, 255,  2036, 1);
		add_row(CMD_READ,   0,    0,    0,    0, 1, STAT_OK,         0, 2048, 0,    2036, 1);
		add_row(CMD_READ,   0,    0,    4095, 0, 1, STAT_POSITION,   0, 2048, 0,    2036, 1);
		add_row(CMD_WRITE,  0,    1,    0,    1, 1, STAT_SLOT_RANGE, 0, 0,    0,    2036, 1);
		add_row(CMD_DELETE, 0,    0,    0,    0, 1, STAT_OK,         0, 2048, 0,    2036, 1);
		add_row(CMD_READ,   0,    0,    0,    0, 1, STAT_DELETED,    0, 0,    0,    2036, 1);
		add_row(CMD_DELETE, 0,    0,    0,    0, 1, STAT_DELETED,    0, 0,    0,    2036, 1);
		add_row(CMD_ALLOC,  2037, 0,    0,    0, 1, STAT_NO_SPACE,   0, 0,    0,    2036, 1);
		add_row(CMD_ALLOC,  3,    0,    0,    0, 1, STAT_OK,         0, 3,    0,    2033, 1);
		add_row(CMD_ALLOC,  4,    0,    0,    0, 1, STAT_OK,         1, 4,    0,    2025, 2);
		add_row(CMD_WRITE,  0,    1,    4095, 9, 1, STAT_POSITION,   0, 4,    0,    2025, 2);
		add_row(CMD_DELETE, 0,    1023, 0,    0, 1, STAT_SLOT_RANGE, 0, 0,    0,    2025, 2);
		add_row(CMD_WRITE,  0,    1,    3,    170, 0, STAT_OK,       0, 0,    0,    0,    0);
		add_row(CMD_READ,   0,    1,    3,    0, 0, STAT_OK,         0, 0,    0,    0,    0);
		add_row(CMD_ALLOC,  1,    0,    0,    0, 0, STAT_OK,         0, 0,    0,    0,    0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) send_word(directed_rows[i]);
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == QUIET_FROM) quiet = 1'b1;
			send_word(random_cmd());
		end
		in_valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_replies.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/spr_pkg.sv
rtl/spr_ctrl.sv
rtl/spr_datapath.sv
rtl/slotted_page_record_store_unit.sv
verif/tb_slotted_page_record_store_unit.sv
